@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ENM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ENM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/enm_pkg.sv @@
// ----------------------------------------------------------------------------
// enm_pkg
// Shared constants and types of the epsilon neighbor mask block.
// ----------------------------------------------------------------------------
package enm_pkg;

  localparam int MAX_POINTS      = 32;
  localparam int FEATURES        = 10;
  localparam int NUM_IN_FEATURES = 10;
  localparam int FEAT_W          = 16;
  localparam int DIFF_W          = FEAT_W + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int SQ_W            = 2 * FEAT_W;
  localparam int PAIR_W          = SQ_W + 1;
  localparam int EPS_W           = 38;
  localparam int MASK_W          = 32;
  localparam int OUT_IDX_W       = 5;
  localparam int IDX_W           = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W           = $clog2(MAX_POINTS + 1);
  localparam int NPAIR           = (FEATURES + 1) / 2;
  localparam int LANES           = 2 * NPAIR;
  localparam int POINT_W         = FEATURES * FEAT_W;

  typedef logic [FEATURES-1:0][FEAT_W-1:0] point_t;

  // Tag that travels with one stored point through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // Compare outcome for one stored point
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic             hit;
  } ret_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

@@ src/enm_ram.sv @@
// ----------------------------------------------------------------------------
// enm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module enm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/enm_dist.sv @@
// ----------------------------------------------------------------------------
// enm_dist
// Five-stage squared-distance pipeline: difference, square per feature lane,
// pair sums, total, and strict compare against the threshold.
// ----------------------------------------------------------------------------
module enm_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [enm_pkg::EPS_W-1:0]   eps,
  input  enm_pkg::point_t             point,
  input  enm_pkg::point_t             rdata,
  input  enm_pkg::tag_t               tag_in,
  output enm_pkg::ret_t               ret
);

  import enm_pkg::*;

  logic [DIFF_W-1:0] diff_nxt [LANES];
  logic [DIFF_W-1:0] diff_r   [LANES];
  logic signed [PROD_W-1:0] prod [LANES];
  logic [SQ_W-1:0]   sq_r     [LANES];
  logic [PAIR_W-1:0] pair_nxt [NPAIR];
  logic [PAIR_W-1:0] pair_r   [NPAIR];
  logic [EPS_W-1:0]  sum_nxt;
  logic [EPS_W-1:0]  sum_r;
  tag_t              t1_r, t2_r, t3_r, t4_r;
  ret_t              ret_r;

  // Feature differences; padding lanes stay zero
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < FEATURES) begin : g_used
      assign diff_nxt[k] = {point[k][FEAT_W-1], point[k]} - {rdata[k][FEAT_W-1], rdata[k]};
    end else begin : g_pad
      assign diff_nxt[k] = '0;
    end
    assign prod[k] = $signed(diff_r[k]) * $signed(diff_r[k]);
  end

  // Pair sums of the lane squares
  always_comb begin
    for (int i = 0; i < NPAIR; i++) begin
      pair_nxt[i] = {1'b0, sq_r[2*i]} + {1'b0, sq_r[2*i+1]};
    end
  end

  // Total of the pair sums
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NPAIR; i++) begin
      sum_nxt = sum_nxt + EPS_W'(pair_r[i]);
    end
  end

  // Advance stage tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      t4_r  <= '0;
      ret_r <= '0;
    end else begin
      t1_r  <= tag_in;
      t2_r  <= t1_r;
      t3_r  <= t2_r;
      t4_r  <= t3_r;
      ret_r <= '{valid: t4_r.valid, last: t4_r.last, idx: t4_r.idx,
                 hit: (sum_r < eps)};
    end
  end

  // Advance stage data
  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      diff_r[k] <= diff_nxt[k];
      sq_r[k]   <= prod[k][SQ_W-1:0];
    end
    for (int i = 0; i < NPAIR; i++) begin
      pair_r[i] <= pair_nxt[i];
    end
    sum_r <= sum_nxt;
  end

  assign ret = ret_r;

endmodule

@@ src/epsilon_neighbor_mask.sv @@
// ----------------------------------------------------------------------------
// epsilon_neighbor_mask
// Epsilon-neighborhood builder: compares each new point with all stored
// points and reports a mask of its neighbors (zero when the store is full).
// ----------------------------------------------------------------------------
// Usage:
//   Input: present new_set and ten Q8.8 features with start; the transfer
//   happens at an edge where start is high and busy is low.
//   Config: cfg_we with cfg_wdata writes the 38-bit squared threshold
//   (Q22.16); write it only while the block is idle. Reset value is 0.
//   Result: out_valid is high for one cycle with point_index, neighbor_mask
//   and store_full. The receiver cannot stall; one result per input item.
//   Scan: with N points already stored (0 < N < MAX_POINTS) the store is
//   read one entry per cycle and each read runs through a five-stage
//   distance pipeline; the result appears when the last compare leaves it
//   and busy drops with the result, so no new item is taken during a scan.
//   The next transfer can come at the edge that takes the result. An empty
//   store or a full store puts the result up at the transfer edge itself,
//   to be taken at the next edge; busy never rises, so such items go back to back.
//   Reset: clears the point count and the threshold; stored points are
//   never read before they are written again, so the store needs no clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epsilon_neighbor_mask (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_new_set,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_0,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_1,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_2,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_3,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_4,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_5,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_6,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_7,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_8,
  input  logic [enm_pkg::FEAT_W-1:0]        in_feature_9,
  input  logic                              cfg_we,
  input  logic [enm_pkg::EPS_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output logic [enm_pkg::OUT_IDX_W-1:0]     out_point_index,
  output logic [enm_pkg::MASK_W-1:0]        out_neighbor_mask,
  output logic                              out_store_full
);

  import enm_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt, mask_hit;
  logic [EPS_W-1:0]     eps_r;
  point_t               point_r, pt_in, rdata;
  tag_t                 tag_r, tag_nxt;
  ret_t                 ret;
  logic [FEAT_W-1:0]    feat_in [NUM_IN_FEATURES];
  logic                 accept, rd_en, is_full, last_issue;
  logic [CNT_W-1:0]     cnt_eff;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [MASK_W-1:0]    out_mask_r, out_mask_nxt;
  logic                 out_full_r, out_full_nxt;

  // Gather the incoming point
  always_comb begin
    feat_in[0] = in_feature_0;
    feat_in[1] = in_feature_1;
    feat_in[2] = in_feature_2;
    feat_in[3] = in_feature_3;
    feat_in[4] = in_feature_4;
    feat_in[5] = in_feature_5;
    feat_in[6] = in_feature_6;
    feat_in[7] = in_feature_7;
    feat_in[8] = in_feature_8;
    feat_in[9] = in_feature_9;
    for (int k = 0; k < FEATURES; k++) begin
      pt_in[k] = feat_in[k];
    end
  end

  assign accept     = start && !busy;
  assign cnt_eff    = in_new_set ? '0 : count_r;
  assign is_full    = (cnt_eff == CNT_W'(MAX_POINTS));
  assign last_issue = ((CNT_W'(j_r) + CNT_W'(1)) == count_r);
  assign mask_hit   = ret.hit ? (MASK_W'(1) << ret.idx) : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_full && (cnt_eff != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (ret.valid && ret.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    case (state_r)
      ST_IDLE:  busy  = 1'b0;
      ST_SCAN:  rd_en = 1'b1;
      ST_DRAIN: rd_en = 1'b0;
      default:  busy  = 1'b1;
    endcase
  end

  // Count, scan index, mask and result
  always_comb begin
    count_nxt     = count_r;
    j_nxt         = j_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_mask_nxt  = out_mask_r;
    out_full_nxt  = out_full_r;
    tag_nxt       = '{valid: rd_en, last: last_issue, idx: j_r};
    if (accept) begin
      if (is_full) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = '0;
        out_mask_nxt  = '0;
        out_full_nxt  = 1'b1;
      end else if (cnt_eff == '0) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = '0;
        out_mask_nxt  = MASK_W'(1);
        out_full_nxt  = 1'b0;
        count_nxt     = CNT_W'(1);
      end else begin
        count_nxt = cnt_eff;
        j_nxt     = '0;
        mask_nxt  = '0;
      end
    end
    if (rd_en) begin
      j_nxt = j_r + IDX_W'(1);
    end
    if (ret.valid) begin
      mask_nxt = mask_r | mask_hit;
      if (ret.last) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = OUT_IDX_W'(count_r);
        out_mask_nxt  = mask_r | mask_hit | (MASK_W'(1) << count_r);
        out_full_nxt  = 1'b0;
        count_nxt     = count_r + CNT_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      j_r         <= '0;
      eps_r       <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      j_r         <= j_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    out_idx_r  <= out_idx_nxt;
    out_mask_r <= out_mask_nxt;
    out_full_r <= out_full_nxt;
    if (accept) begin
      point_r <= pt_in;
    end
  end

  // Point store: write the new point at transfer, read stored points in scan
  enm_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (accept && !is_full),
    .waddr (cnt_eff[IDX_W-1:0]),
    .wdata (pt_in),
    .re    (rd_en),
    .raddr (j_r),
    .rdata (rdata)
  );

  enm_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .eps    (eps_r),
    .point  (point_r),
    .rdata  (rdata),
    .tag_in (tag_r),
    .ret    (ret)
  );

  assign out_valid         = out_valid_r;
  assign out_point_index   = out_idx_r;
  assign out_neighbor_mask = out_mask_r;
  assign out_store_full    = out_full_r;

  `ENM_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_POINTS))
  `ENM_ASSERT_IMP(a_full_clean, clk, rst_n, out_valid && out_store_full, out_neighbor_mask == '0)
  `ENM_ASSERT_IMP(a_ret_busy, clk, rst_n, ret.valid, state_r != ST_IDLE)
  `ENM_ASSERT_NXT(a_full_next, clk, rst_n, accept && is_full, out_valid && out_store_full)

endmodule
